[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mccp_pkg.sv]
package mccp_pkg;

  localparam int SAMPLE_FRAC_BITS_DEF = 12;

  localparam int SQ_W   = 34;
  localparam int HV_W   = 43;
  localparam int RT_W   = 41;
  localparam int SV_W   = 38;
  localparam int MANT_W = 32;
  localparam int PATH_W = 35;

  localparam int TAYLOR_TERMS = 20;
  localparam int EXP_LAT      = 5 + 3 * (TAYLOR_TERMS - 1);

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  localparam logic [PATH_W-1:0] PATH_CAP = PATH_W'(64'd1 << 34);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPOT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTI   = 3'd5;

  localparam logic [31:0] SPOT_RST   = 32'd6553600;
  localparam logic [31:0] STRIKE_RST = 32'd6553600;
  localparam logic [31:0] RATE_RST   = 32'd0;
  localparam logic [31:0] VOL_RST    = 32'd214748365;
  localparam logic [31:0] MAT_RST    = 32'd16777216;

  typedef enum logic [2:0] {
    PC_SQ,
    PC_HV_LO,
    PC_HV,
    PC_RT,
    PC_SQRT,
    PC_SV,
    PC_IDLE
  } pc_state_t;

endpackage

[rtl/core/mccp_exp.sv]
module mccp_exp
  import mccp_pkg::*;
#(
  parameter int Z_W = 45
) (
  input  logic                   clk,
  input  logic signed [Z_W-1:0]  exp_z,
  output logic [MANT_W-1:0]      exp_m,
  output logic signed [Z_W-31:0] exp_n
);

  localparam int AZ_W  = Z_W - 1;
  localparam int HI_W  = AZ_W - 32;
  localparam int N_W   = Z_W - 30;
  localparam int STEPS = TAYLOR_TERMS - 1;

  logic [AZ_W-1:0]       az;
  logic                  zneg_r;
  logic [63:0]           plo_r;
  logic [HI_W+31:0]      phi_r;
  logic [AZ_W+31:0]      ysum;
  logic [AZ_W:0]         ym_r;
  logic                  ym_neg_r;
  logic [AZ_W+1:0]       ym_ceil;
  logic signed [N_W-1:0] n_calc;
  logic signed [N_W-1:0] n3_r;
  logic [31:0]           f_r;
  logic [63:0]           tprod;
  logic [31:0]           t_r;
  logic signed [N_W-1:0] n4_r;

  logic [31:0]           term_c [STEPS+1];
  logic [33:0]           sum_c  [STEPS+1];
  logic [31:0]           t_c    [STEPS+1];
  logic signed [N_W-1:0] n_c    [STEPS+1];

  assign az = AZ_W'(exp_z[Z_W-1] ? -exp_z : exp_z);

  // log2(e) scaling, split into two partial products
  always_ff @(posedge clk) begin
    zneg_r <= exp_z[Z_W-1];
    plo_r  <= 64'(az[31:0]) * 64'(LOG2E_Q30);
    phi_r  <= (HI_W+32)'(az[AZ_W-1:32]) * (HI_W+32)'(LOG2E_Q30);
  end

  assign ysum = (AZ_W+32)'(plo_r) + {phi_r, 32'd0};

  always_ff @(posedge clk) begin
    ym_r     <= ysum[AZ_W+30:30];
    ym_neg_r <= zneg_r;
  end

  // split into integer exponent and fraction
  assign ym_ceil = (AZ_W+2)'(ym_r) + (AZ_W+2)'(32'hFFFF_FFFF);
  assign n_calc  = ym_neg_r ? -N_W'(ym_ceil[AZ_W+1:32]) : N_W'(ym_r[AZ_W:32]);

  always_ff @(posedge clk) begin
    n3_r <= n_calc;
    f_r  <= ym_neg_r ? 32'd0 - ym_r[31:0] : ym_r[31:0];
  end

  assign tprod = 64'(f_r) * 64'(LN2_Q32);

  always_ff @(posedge clk) begin
    t_r  <= tprod[63:32];
    n4_r <= n3_r;
  end

  // first Taylor term is t itself
  always_ff @(posedge clk) begin
    term_c[0] <= t_r;
    sum_c[0]  <= 34'h1_0000_0000 + 34'(t_r);
    t_c[0]    <= t_r;
    n_c[0]    <= n4_r;
  end

  for (genvar j = 1; j <= STEPS; j++) begin : g_term
    localparam int          K     = j + 1;
    localparam logic [31:0] Recip = 32'((64'd1 << 32) / K);

    logic [63:0]           xprod;
    logic [31:0]           xa_r;
    logic [31:0]           ta_r;
    logic [33:0]           sa_r;
    logic signed [N_W-1:0] na_r;
    logic [63:0]           qprod;
    logic [31:0]           q0_r;
    logic [31:0]           xb_r;
    logic [31:0]           tb_r;
    logic [33:0]           sb_r;
    logic signed [N_W-1:0] nb_r;
    logic [36:0]           qk;
    logic [36:0]           rem;
    logic [31:0]           q;

    assign xprod = 64'(term_c[j-1]) * 64'(t_c[j-1]);

    always_ff @(posedge clk) begin
      xa_r <= xprod[63:32];
      ta_r <= t_c[j-1];
      sa_r <= sum_c[j-1];
      na_r <= n_c[j-1];
    end

    // divide by K: reciprocal estimate, low by at most one
    assign qprod = 64'(xa_r) * 64'(Recip);

    always_ff @(posedge clk) begin
      q0_r <= qprod[63:32];
      xb_r <= xa_r;
      tb_r <= ta_r;
      sb_r <= sa_r;
      nb_r <= na_r;
    end

    assign qk  = 37'(q0_r) * 37'(K);
    assign rem = 37'(xb_r) - qk;
    assign q   = (rem >= 37'(K)) ? q0_r + 32'd1 : q0_r;

    always_ff @(posedge clk) begin
      term_c[j] <= q;
      sum_c[j]  <= sb_r + 34'(q);
      t_c[j]    <= tb_r;
      n_c[j]    <= nb_r;
    end
  end

  assign exp_m = sum_c[STEPS][33:2];
  assign exp_n = n_c[STEPS];

endmodule

[rtl/core/monte_carlo_call_payoff.sv]
// Discounted European call payoff per standard normal sample, with optional
// antithetic pairing. One sample is taken per clock while busy is low, and
// its result appears on out_strobe; the pipeline keeps one item in every
// stage, so results stream at one per cycle while samples are taken. The
// receiver cannot stall. After reset and after every configuration write,
// busy stays high while the sample-independent terms (variance drift,
// sigma*sqrt(T) through a bit-serial square root, and r*T) are rebuilt;
// write configuration only while no result is still outstanding.
`include "assert_macros.svh"

module monte_carlo_call_payoff
  import mccp_pkg::*;
#(
  parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   in_normal_sample,
  output logic                 out_strobe,
  output logic [31:0]          out_discounted_payoff,
  output logic                 out_saturated,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int DM_W     = SV_W + 16 - SAMPLE_FRAC_BITS;
  localparam int Z_W      = ((DM_W > HV_W) ? DM_W : HV_W) + 2;
  localparam int N_W      = Z_W - 30;
  localparam int PIPE_LAT = EXP_LAT + 7;

  logic [31:0] spot_r;
  logic [31:0] strike_r;
  logic [31:0] rate_r;
  logic [31:0] vol_r;
  logic [31:0] mat_r;
  logic        anti_r;

  pc_state_t   pc_state_r, pc_state_nxt;
  logic [SQ_W-1:0] sq_r, sq_nxt;
  logic [63:0]     hvlo_r, hvlo_nxt;
  logic [HV_W-1:0] hv_r, hv_nxt;
  logic [RT_W-1:0] rt_r, rt_nxt;
  logic [SV_W-1:0] sv_r, sv_nxt;
  logic [55:0]     rem_r, rem_nxt;
  logic [55:0]     root_r, root_nxt;
  logic [54:0]     sq_bit_r, sq_bit_nxt;
  logic [56:0]     trial;
  logic [66:0]     hv_sum;
  logic [31:0]     rabs;
  logic [63:0]     rt_prod;
  logic [63:0]     sv_prod;
  logic [63:0]     sq_prod;

  logic [PIPE_LAT-1:0] pipe_vld_r;
  logic                accept;

  logic [15:0]            w_abs_r;
  logic                   w_neg_r;
  logic [53:0]            dm_prod;
  logic [DM_W-1:0]        dm_r;
  logic                   dm_neg_r;
  logic signed [Z_W-1:0]  dm_s;
  logic signed [Z_W-1:0]  hv_s;
  logic signed [Z_W-1:0]  rt_s;
  logic signed [Z_W-1:0]  d_s;
  logic signed [Z_W-1:0]  zm_r;
  logic signed [Z_W-1:0]  zr_r;
  logic signed [Z_W-1:0]  zb;

  logic [MANT_W-1:0]      m_main, m_mir, m_b;
  logic signed [N_W-1:0]  n_main, n_mir, n_b;

  logic [63:0]            a1_r [2];
  logic signed [N_W-1:0]  n1_r [2];
  logic [63:0]            a2_r;
  logic signed [N_W-1:0]  n2_r;
  logic [PATH_W-1:0]      path_r [2];

  logic [PATH_W:0]        pair_sum;
  logic [PATH_W-1:0]      mean;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_r   <= SPOT_RST;
      strike_r <= STRIKE_RST;
      rate_r   <= RATE_RST;
      vol_r    <= VOL_RST;
      mat_r    <= MAT_RST;
      anti_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPOT:   spot_r   <= cfg_wdata;
        CFG_STRIKE: strike_r <= cfg_wdata;
        CFG_RATE:   rate_r   <= cfg_wdata;
        CFG_VOL:    vol_r    <= cfg_wdata;
        CFG_MAT:    mat_r    <= cfg_wdata;
        CFG_ANTI:   anti_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------- precompute sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_state_r <= PC_SQ;
    end else begin
      pc_state_r <= pc_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_r     <= sq_nxt;
    hvlo_r   <= hvlo_nxt;
    hv_r     <= hv_nxt;
    rt_r     <= rt_nxt;
    sv_r     <= sv_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    sq_bit_r <= sq_bit_nxt;
  end

  assign rabs    = rate_r[31] ? 32'd0 - rate_r : rate_r;
  assign trial   = 57'(root_r) + 57'(sq_bit_r);
  assign sq_prod = 64'(vol_r) * 64'(vol_r);
  assign rt_prod = 64'(rabs) * 64'(mat_r);
  assign sv_prod = 64'(vol_r) * 64'(root_r[27:0]);
  assign hv_sum  = 67'(hvlo_r) + {1'b0, 34'(sq_r[33:32]) * 34'(mat_r), 32'd0};

  always_comb begin
    pc_state_nxt = pc_state_r;
    sq_nxt       = sq_r;
    hvlo_nxt     = hvlo_r;
    hv_nxt       = hv_r;
    rt_nxt       = rt_r;
    sv_nxt       = sv_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    sq_bit_nxt   = sq_bit_r;
    unique case (pc_state_r)
      PC_SQ: begin
        sq_nxt       = sq_prod[63:30];
        rem_nxt      = {mat_r, 24'd0};
        root_nxt     = 56'd0;
        sq_bit_nxt   = 55'(64'd1 << 54);
        pc_state_nxt = PC_HV_LO;
      end
      PC_HV_LO: begin
        hvlo_nxt     = 64'(sq_r[31:0]) * 64'(mat_r);
        pc_state_nxt = PC_HV;
      end
      PC_HV: begin
        hv_nxt       = hv_sum[HV_W+22:23];
        pc_state_nxt = PC_RT;
      end
      PC_RT: begin
        rt_nxt       = rt_prod[RT_W+21:22];
        pc_state_nxt = PC_SQRT;
      end
      PC_SQRT: begin
        if (57'(rem_r) >= trial) begin
          rem_nxt  = 56'(57'(rem_r) - trial);
          root_nxt = (root_r >> 1) + 56'(sq_bit_r);
        end else begin
          root_nxt = root_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        if (sq_bit_r == 55'd1) begin
          pc_state_nxt = PC_SV;
        end
      end
      PC_SV: begin
        sv_nxt       = sv_prod[SV_W+21:22];
        pc_state_nxt = PC_IDLE;
      end
      PC_IDLE: ;
    endcase
    if (cfg_we) begin
      pc_state_nxt = PC_SQ;
    end
  end

  assign busy   = (pc_state_r != PC_IDLE);
  assign accept = start && !busy;

  // ------------------------------------------------------------ valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_vld_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      pipe_vld_r <= {pipe_vld_r[PIPE_LAT-2:0], accept};
      out_strobe <= pipe_vld_r[PIPE_LAT-1];
    end
  end

  // ---------------------------------------------------------- sample side
  always_ff @(posedge clk) begin
    w_neg_r <= in_normal_sample[15];
    w_abs_r <= in_normal_sample[15] ? 16'd0 - in_normal_sample : in_normal_sample;
  end

  assign dm_prod = 54'(sv_r) * 54'(w_abs_r);

  always_ff @(posedge clk) begin
    dm_r     <= DM_W'(dm_prod >> SAMPLE_FRAC_BITS);
    dm_neg_r <= w_neg_r;
  end

  assign dm_s = Z_W'(dm_r);
  assign hv_s = Z_W'(hv_r);
  assign rt_s = Z_W'(rt_r);
  assign d_s  = dm_neg_r ? -dm_s : dm_s;
  assign zb   = rate_r[31] ? rt_s : -rt_s;

  always_ff @(posedge clk) begin
    zm_r <= d_s - hv_s;
    zr_r <= -d_s - hv_s;
  end

  mccp_exp #(.Z_W(Z_W)) u_exp_main (
    .clk   (clk),
    .exp_z (zm_r),
    .exp_m (m_main),
    .exp_n (n_main)
  );

  mccp_exp #(.Z_W(Z_W)) u_exp_mir (
    .clk   (clk),
    .exp_z (zr_r),
    .exp_m (m_mir),
    .exp_n (n_mir)
  );

  mccp_exp #(.Z_W(Z_W)) u_exp_disc (
    .clk   (clk),
    .exp_z (zb),
    .exp_m (m_b),
    .exp_n (n_b)
  );

  // ---------------------------------------------------------- path values
  always_ff @(posedge clk) begin
    a1_r[0] <= 64'(spot_r) * 64'(m_main);
    a1_r[1] <= 64'(spot_r) * 64'(m_mir);
    n1_r[0] <= n_main;
    n1_r[1] <= n_mir;
    a2_r    <= 64'(strike_r) * 64'(m_b);
    n2_r    <= n_b;
  end

  for (genvar g = 0; g < 2; g++) begin : g_path
    logic signed [N_W:0]   ndiff;
    logic signed [N_W:0]   nneg;
    logic [63:0]           a1s_r;
    logic [63:0]           a2s_r;
    logic signed [N_W-1:0] e_r;
    logic                  pos_r;
    logic [63:0]           diff_r;
    logic signed [N_W:0]   k_r;
    logic signed [N_W:0]   kneg;
    logic [97:0]           wide;
    logic [63:0]           shr;

    assign ndiff = (N_W+1)'(n1_r[g]) - (N_W+1)'(n2_r);
    assign nneg  = -ndiff;

    // align the smaller exponent to the larger
    always_ff @(posedge clk) begin
      if (!ndiff[N_W]) begin
        a1s_r <= a1_r[g];
        a2s_r <= (ndiff >= 63) ? 64'd0 : a2_r >> ndiff[5:0];
        e_r   <= n1_r[g];
      end else begin
        a1s_r <= (nneg >= 63) ? 64'd0 : a1_r[g] >> nneg[5:0];
        a2s_r <= a2_r;
        e_r   <= n2_r;
      end
    end

    always_ff @(posedge clk) begin
      pos_r  <= a1s_r > a2s_r;
      diff_r <= a1s_r - a2s_r;
      k_r    <= (N_W+1)'(e_r) - (N_W+1)'(30);
    end

    assign kneg = -k_r;
    assign wide = {34'd0, diff_r} << k_r[5:0];
    assign shr  = diff_r >> kneg[5:0];

    // scale to Q16.16 and clamp
    always_ff @(posedge clk) begin
      if (!pos_r) begin
        path_r[g] <= '0;
      end else if (!k_r[N_W]) begin
        if (k_r >= 34 || wide > 98'(PATH_CAP)) begin
          path_r[g] <= PATH_CAP;
        end else begin
          path_r[g] <= wide[PATH_W-1:0];
        end
      end else if (kneg >= 64) begin
        path_r[g] <= '0;
      end else if (shr > 64'(PATH_CAP)) begin
        path_r[g] <= PATH_CAP;
      end else begin
        path_r[g] <= shr[PATH_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------- output
  assign pair_sum = (PATH_W+1)'(path_r[0]) + (PATH_W+1)'(path_r[1]);
  assign mean     = anti_r ? pair_sum[PATH_W:1] : path_r[0];

  always_ff @(posedge clk) begin
    if (mean > PATH_W'(32'hFFFF_FFFF)) begin
      out_discounted_payoff <= 32'hFFFF_FFFF;
      out_saturated         <= 1'b1;
    end else begin
      out_discounted_payoff <= mean[31:0];
      out_saturated         <= 1'b0;
    end
  end

  // ----------------------------------------------------------- assertions
  `ASSERT_IMPL(a_sat_all_ones, clk, rst_n, out_strobe && out_saturated,
    out_discounted_payoff == 32'hFFFF_FFFF, "saturated result is not all ones")
  `ASSERT_NEXT(a_cfg_busy, clk, rst_n, cfg_we, busy,
    "configuration write did not restart precompute")
  `ASSERT_IMPL(a_sqrt_bit, clk, rst_n, pc_state_r == PC_SQRT, sq_bit_r != 55'd0,
    "square root ran past its last digit")

endmodule

[dv/monte_carlo_call_payoff_tb.sv]
`timescale 1ns / 100ps

module monte_carlo_call_payoff_tb;
  import mccp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam bit [63:0] CAP_34 = 64'd1 << 34;

  typedef struct {
    bit [31:0] payoff;
    bit        sat;
  } payoff_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [15:0]   in_normal_sample;
  logic                 out_strobe;
  logic [31:0]          out_discounted_payoff;
  logic                 out_saturated;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  bit [63:0] m_spot, m_strike, m_rate, m_vol, m_mat;
  bit        m_anti;
  payoff_t   payoff_q[$];
  int        n_errors;

  monte_carlo_call_payoff u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_normal_sample(in_normal_sample), .out_strobe(out_strobe),
    .out_discounted_payoff(out_discounted_payoff), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic bit [63:0] mul_shift(bit [63:0] a, bit [63:0] b, int k);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[63+k -: 64];
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic bit [63:0] exp_mantissa(longint z, output longint n);
    bit [63:0] az, ym, f, t, sum, term;
    az = (z < 0) ? 64'(-z) : 64'(z);
    ym = mul_shift(az, 64'(LOG2E_Q30), 30);
    if (z < 0) begin
      n = -longint'((ym + 64'hFFFF_FFFF) >> 32);
      f = (64'd0 - ym) & 64'hFFFF_FFFF;
    end else begin
      n = longint'(ym >> 32);
      f = ym & 64'hFFFF_FFFF;
    end
    t = (f * 64'(LN2_Q32)) >> 32;
    sum = 64'd1 << 32;
    term = sum;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * t) >> 32) / k;
      sum += term;
    end
    return sum >> 2;
  endfunction

  function automatic bit [63:0] path_payoff(longint a, longint b);
    longint n1, n2, e, k;
    bit [63:0] m1, m2, a1, a2, d, s;
    m1 = exp_mantissa(a, n1);
    m2 = exp_mantissa(b, n2);
    a1 = m_spot * m1;
    a2 = m_strike * m2;
    if (n1 >= n2) begin
      s = 64'(n1 - n2);
      a2 = (s >= 63) ? 64'd0 : a2 >> s;
      e = n1;
    end else begin
      s = 64'(n2 - n1);
      a1 = (s >= 63) ? 64'd0 : a1 >> s;
      e = n2;
    end
    if (a1 <= a2) return 0;
    d = a1 - a2;
    k = e - 30;
    if (k >= 0) begin
      if (k >= 34 || d > (CAP_34 >> k)) return CAP_34;
      return d << k;
    end
    if (-k >= 64) return 0;
    d >>= (-k);
    return (d > CAP_34) ? CAP_34 : d;
  endfunction

  function automatic payoff_t call_payoff(logic [15:0] sample);
    payoff_t   r;
    bit        wneg, rneg;
    bit [63:0] wabs, rabs, sq, sqrt_t, sv, p;
    longint    half_var, dm, d, rt, b;
    wneg = sample[15];
    wabs = wneg ? 64'h1_0000 - {48'd0, sample} : {48'd0, sample};
    rneg = m_rate[31];
    rabs = rneg ? 64'h1_0000_0000 - m_rate : m_rate;
    sq = mul_shift(m_vol, m_vol, 30);
    half_var = longint'(mul_shift(sq, m_mat, 23));
    sqrt_t = int_sqrt(m_mat << 24);
    sv = mul_shift(m_vol, sqrt_t, 22);
    dm = longint'(mul_shift(sv, wabs, SAMPLE_FRAC_BITS_DEF));
    d = wneg ? -dm : dm;
    rt = longint'(mul_shift(rabs, m_mat, 22));
    b = rneg ? rt : -rt;
    p = path_payoff(d - half_var, b);
    if (m_anti) p = (p + path_payoff(-d - half_var, b)) >> 1;
    if (p > 64'hFFFF_FFFF) begin
      r.payoff = 32'hFFFF_FFFF;
      r.sat = 1'b1;
    end else begin
      r.payoff = p[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    payoff_t want;
    if (rst_n && out_strobe) begin
      if (payoff_q.size() == 0) begin
        report_mismatch("unexpected result", out_discounted_payoff, 0);
      end else begin
        want = payoff_q.pop_front();
        if (out_discounted_payoff !== want.payoff)
          report_mismatch("payoff", out_discounted_payoff, want.payoff);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", out_saturated, want.sat);
      end
    end
  end

  task automatic send_sample(logic [15:0] sample);
    @(negedge clk);
    start <= 1'b1;
    in_normal_sample <= sample;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    payoff_q.push_back(call_payoff(sample));
  endtask

  task automatic pause(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      in_normal_sample <= 16'($urandom);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    while (payoff_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SPOT:   m_spot = {32'd0, val};
      CFG_STRIKE: m_strike = {32'd0, val};
      CFG_RATE:   m_rate = {32'd0, val};
      CFG_VOL:    m_vol = {32'd0, val};
      CFG_MAT:    m_mat = {32'd0, val};
      CFG_ANTI:   m_anti = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] s, logic [31:0] k, logic [31:0] r,
                         logic [31:0] v, logic [31:0] t, bit anti);
    write_reg(CFG_SPOT, s);
    write_reg(CFG_STRIKE, k);
    write_reg(CFG_RATE, r);
    write_reg(CFG_VOL, v);
    write_reg(CFG_MAT, t);
    write_reg(CFG_ANTI, {31'd0, anti});
  endtask

  task automatic send_edge_samples();
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h1000);
    send_sample(16'hF000);
    pause(1);
  endtask

  task automatic test_reset_config();
    send_edge_samples();
    send_sample(16'h2000);
    send_sample(16'hE000);
    pause(2);
  endtask

  task automatic test_extremes();
    set_all(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_edge_samples();
    set_all(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 1'b1);
    send_edge_samples();
    set_all(32'hFFFF_FFFF, 32'd100 << 16, 32'd0, 32'd214748365, 32'd16777216, 1'b1);
    send_edge_samples();
  endtask

  task automatic test_unused_index();
    write_reg(CFG_UNUSED_LO, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED_HI, 32'h0);
    send_edge_samples();
  endtask

  task automatic test_random(int n_items);
    int sent, burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        set_all($urandom_range(50, 200) << 16, $urandom_range(50, 200) << 16,
                $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 27)) :
                                       -32'($urandom_range(0, 1 << 27)),
                $urandom_range(1 << 26, 1 << 29), $urandom_range(1 << 22, 1 << 26),
                1'($urandom_range(0, 1)));
      end else begin
        set_all($urandom, $urandom, $urandom, $urandom, $urandom,
                1'($urandom_range(0, 1)));
      end
      for (int i = 0; i < 10 && sent < n_items; i++) begin
        burst = $urandom_range(1, 20);
        repeat (burst) begin
          send_sample(16'($urandom));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
      end
      pause(1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_normal_sample = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    n_errors = 0;
    m_spot = SPOT_RST;
    m_strike = STRIKE_RST;
    m_rate = RATE_RST;
    m_vol = VOL_RST;
    m_mat = MAT_RST;
    m_anti = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_extremes();
    test_unused_index();
    test_random(1100);

    pause(1);
    while (payoff_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mccp_pkg.sv
rtl/core/mccp_exp.sv
rtl/core/monte_carlo_call_payoff.sv
dv/monte_carlo_call_payoff_tb.sv
